[sv/scs_pkg.sv]
// Shared types, constants and helpers of the strided convolution stream block.
// No dependencies; every other file except scs_ram imports this package.
package scs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_KERNEL = 8;     // power of two: line slots wrap by masking
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_STEP   = 8;

  localparam int PIX_W     = 16;
  localparam int PROD_W    = 2 * PIX_W;
  localparam int ROW_SUM_W = PROD_W + $clog2(MAX_KERNEL);
  localparam int CONV_W    = 40;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int SLOT_W    = $clog2(MAX_KERNEL);
  localparam int WIDX_W    = $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int NWEIGHT   = MAX_KERNEL * MAX_KERNEL;

  localparam int FW_W  = 11;
  localparam int FH_W  = 13;
  localparam int KS_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_PIXEL  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_ROWS  = 3'd2,
    REG_KERNEL_COLS  = 3'd3,
    REG_STEP_SIZE    = 3'd4
  } cfg_reg_e;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef pix_t [MAX_KERNEL-1:0]    col_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [MAX_KERNEL-1:0]   prod_col_t;

  // Per-cycle controls of one window column cell
  typedef struct packed {
    logic shift;
    logic prod;
  } cell_ctl_t;

  // Flat weight slot of window position (row i from newest, column j)
  function automatic logic [WIDX_W-1:0] wt_slot(input int i, input int j,
                                                input logic [KS_W-1:0] kr,
                                                input logic [KS_W-1:0] kc);
    int k1;
    int k2;
    k1 = int'(kr) - 1 - i;
    k2 = j + int'(kc) - MAX_KERNEL;
    return WIDX_W'(k1 * int'(kc) + k2);
  endfunction

endpackage

[sv/scs_chan_if.sv]
// Stream channels of the strided convolution block: item in, result out, config write.
// Depends on scs_pkg for field widths.
interface scs_item_if import scs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [WIDX_W-1:0]       weight_index;
  logic signed [PIX_W-1:0] weight_value;
  logic signed [PIX_W-1:0] pixel_value;
  modport source (output valid, opcode, weight_index, weight_value, pixel_value,
                  input ready);
  modport sink (input valid, opcode, weight_index, weight_value, pixel_value,
                output ready);
endinterface

interface scs_result_if import scs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CONV_W-1:0] conv_value;
  logic                     row_last;
  logic                     frame_last;
  modport source (output valid, conv_value, row_last, frame_last, input ready);
  modport sink (input valid, conv_value, row_last, frame_last, output ready);
endinterface

interface scs_cfg_if import scs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/scs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[sv/scs_col_cell.sv]
// One window column cell: holds a column of pixels, hands it left, multiplies by weights.
// Depends on scs_pkg.
module scs_col_cell import scs_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  col_t      col_i,
  input  col_t      wsel_i,
  output col_t      col_o,
  output prod_col_t prod_o
);
  col_t      pix_q;
  prod_col_t prod_q;

  // Take the right neighbor's column; form products of the held column
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      pix_q <= col_i;
    end
    if (ctl_i.prod) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        prod_q[i] <= $signed(pix_q[i]) * $signed(wsel_i[i]);
      end
    end
  end

  assign col_o  = pix_q;
  assign prod_o = prod_q;
endmodule

[sv/strided_conv2d_stream_top.sv]
// Strided 2D convolution over a raster pixel stream, line buffers and a column cell chain.
// Throughput: one item per cycle while the result channel is not stalled.
// The rate is set by the line RAM read (one column per cycle) and 64 parallel multipliers.
// A stalled result holds the whole pipeline; the input is taken whenever it can move.
// Reset (async, active low) clears counters, weights and valid bits; line RAM is not cleared.
module strided_conv2d_stream_top import scs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  scs_item_if.sink     item_i,
  scs_result_if.source result_o,
  scs_cfg_if.sink      cfg_i
);
  // Configuration registers and clamped values
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [KS_W-1:0] kr_q, kc_q, st_q;
  logic [FW_W-1:0] wc;
  logic [FH_W-1:0] hc;
  logic [KS_W-1:0] krc, kcc, stc;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] xmod_q, xmod_d, ymod_q, ymod_d;

  logic adv, acc_in, pix_acc, cfg_hit;
  logic emit0, rl0, fl0;

  logic              s1_valid_q, s1_op_q, s1_emit_q, s1_rl_q, s1_fl_q;
  pix_t              s1_data_q;
  logic [WIDX_W-1:0] s1_widx_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s2_valid_q, s2_rl_q, s2_fl_q;
  logic              s3_valid_q, s3_rl_q, s3_fl_q;
  logic              s4_valid_q, s4_rl_q, s4_fl_q;
  logic signed [ROW_SUM_W-1:0] rs_q [MAX_KERNEL];
  logic signed [ROW_SUM_W-1:0] rs_d [MAX_KERNEL];
  logic signed [CONV_W-1:0]    sum_d;

  logic                     res_valid_q, res_rl_q, res_fl_q;
  logic signed [CONV_W-1:0] res_conv_q;

  pix_t      weight_q [NWEIGHT];
  pix_t      rd [MAX_KERNEL];
  col_t      chain [MAX_KERNEL+1];
  col_t      wsel [MAX_KERNEL];
  prod_col_t prod [MAX_KERNEL];
  cell_ctl_t cell_ctl;

  logic [COL_W:0]   c_inc;
  logic [ROW_W:0]   r_inc;
  logic             col_wrap;
  logic [COL_W:0]   c_nxt1;
  logic [ROW_W:0]   r_nxt1;

  // Clamp configuration to legal ranges
  always_comb begin
    wc  = (fw_q == '0) ? FW_W'(1) : ((fw_q > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_q);
    hc  = (fh_q == '0) ? FH_W'(1) : ((fh_q > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_q);
    krc = (kr_q == '0) ? KS_W'(1) : ((kr_q > KS_W'(MAX_KERNEL)) ? KS_W'(MAX_KERNEL) : kr_q);
    kcc = (kc_q == '0) ? KS_W'(1) : ((kc_q > KS_W'(MAX_KERNEL)) ? KS_W'(MAX_KERNEL) : kc_q);
    stc = (st_q == '0) ? KS_W'(1) : ((st_q > KS_W'(MAX_STEP)) ? KS_W'(MAX_STEP) : st_q);
  end

  // Handshakes: whole pipeline moves when the result register can move
  assign adv          = !res_valid_q || result_o.ready;
  assign item_i.ready = adv;
  assign acc_in       = item_i.valid && adv;
  assign pix_acc      = acc_in && (op_e'(item_i.opcode) == OP_PIXEL);
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    case (cfg_reg_e'(cfg_i.index))
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_KERNEL_ROWS,
      REG_KERNEL_COLS, REG_STEP_SIZE: cfg_hit = cfg_i.valid;
      default:                        cfg_hit = 1'b0;
    endcase
  end

  // Window position test and last flags for the current pixel
  always_comb begin
    c_inc = {1'b0, col_q} + (COL_W+1)'(1);
    r_inc = {1'b0, row_q} + (ROW_W+1)'(1);
    emit0 = (wc >= FW_W'(kcc)) && (hc >= FH_W'(krc)) &&
            (r_inc >= (ROW_W+1)'(krc)) && (c_inc >= (COL_W+1)'(kcc)) &&
            (xmod_q == '0) && (ymod_q == '0);
    rl0   = ((COL_W+2)'(c_inc) + (COL_W+2)'(stc)) > (COL_W+2)'(wc);
    fl0   = rl0 && (((ROW_W+2)'(r_inc) + (ROW_W+2)'(stc)) > (ROW_W+2)'(hc));
  end

  // Advance column, row and stride phases
  always_comb begin
    col_wrap = (c_inc == (COL_W+1)'(wc));
    col_d    = col_wrap ? '0 : c_inc[COL_W-1:0];
    row_d    = row_q;
    ymod_d   = ymod_q;
    c_nxt1   = {1'b0, col_d} + (COL_W+1)'(1);
    if (c_nxt1 == (COL_W+1)'(kcc)) begin
      xmod_d = '0;
    end else if ({1'b0, xmod_q} == KS_W'(stc - KS_W'(1))) begin
      xmod_d = '0;
    end else begin
      xmod_d = xmod_q + SLOT_W'(1);
    end
    if (col_wrap) begin
      row_d = (r_inc == (ROW_W+1)'(hc)) ? '0 : r_inc[ROW_W-1:0];
    end
    r_nxt1 = {1'b0, row_d} + (ROW_W+1)'(1);
    if (col_wrap) begin
      if (r_nxt1 == (ROW_W+1)'(krc)) begin
        ymod_d = '0;
      end else if ({1'b0, ymod_q} == KS_W'(stc - KS_W'(1))) begin
        ymod_d = '0;
      end else begin
        ymod_d = ymod_q + SLOT_W'(1);
      end
    end
  end

  // Writes to mapped configuration registers restart the frame; accepted pixels advance counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_W'(64);
      fh_q   <= FH_W'(64);
      kr_q   <= KS_W'(3);
      kc_q   <= KS_W'(3);
      st_q   <= KS_W'(1);
      col_q  <= '0;
      row_q  <= '0;
      xmod_q <= '0;
      ymod_q <= '0;
    end else if (cfg_hit) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FRAME_WIDTH:  fw_q <= cfg_i.data[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_i.data[FH_W-1:0];
        REG_KERNEL_ROWS:  kr_q <= cfg_i.data[KS_W-1:0];
        REG_KERNEL_COLS:  kc_q <= cfg_i.data[KS_W-1:0];
        REG_STEP_SIZE:    st_q <= cfg_i.data[KS_W-1:0];
        default: ;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      xmod_q <= '0;
      ymod_q <= '0;
    end else if (pix_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      xmod_q <= xmod_d;
      ymod_q <= ymod_d;
    end
  end

  // Line buffers: one RAM per row slot, all read at the current column
  for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_line
    scs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk_i   (clk_i),
      .we_i    (pix_acc && (row_q[SLOT_W-1:0] == SLOT_W'(k))),
      .waddr_i (col_q),
      .wdata_i (item_i.pixel_value),
      .re_i    (pix_acc),
      .raddr_i (col_q),
      .rdata_o (rd[k])
    );
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc_in;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_op_q   <= item_i.opcode;
      s1_emit_q <= emit0;
      s1_rl_q   <= rl0;
      s1_fl_q   <= fl0;
      s1_data_q <= (op_e'(item_i.opcode) == OP_PIXEL) ? item_i.pixel_value
                                                      : item_i.weight_value;
      s1_widx_q <= item_i.weight_index;
      s1_slot_q <= row_q[SLOT_W-1:0];
    end
  end

  // Weight store, written in step with window updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NWEIGHT; n++) begin
        weight_q[n] <= '0;
      end
    end else if (adv && s1_valid_q && (op_e'(s1_op_q) == OP_WEIGHT)) begin
      weight_q[s1_widx_q] <= s1_data_q;
    end
  end

  // New column enters the chain at the right end
  always_comb begin
    chain[MAX_KERNEL][0] = s1_data_q;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      chain[MAX_KERNEL][d] = rd[s1_slot_q - SLOT_W'(d)];
    end
  end

  assign cell_ctl.shift = adv && s1_valid_q && (op_e'(s1_op_q) == OP_PIXEL);
  assign cell_ctl.prod  = adv;

  // Route the weight of each window position, zero outside the kernel
  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        if ((i < int'(krc)) && (j + int'(kcc) >= MAX_KERNEL)) begin
          wsel[j][i] = weight_q[wt_slot(i, j, krc, kcc)];
        end else begin
          wsel[j][i] = '0;
        end
      end
    end
  end

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
    scs_col_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .col_i  (chain[j+1]),
      .wsel_i (wsel[j]),
      .col_o  (chain[j]),
      .prod_o (prod[j])
    );
  end

  // Sum products per window row, then over rows
  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      rs_d[i] = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
        rs_d[i] = rs_d[i] + ROW_SUM_W'(prod[j][i]);
      end
    end
    sum_d = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      sum_d = sum_d + CONV_W'(rs_q[i]);
    end
  end

  // Stages 2 to 4 and the result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q  <= s1_valid_q && (op_e'(s1_op_q) == OP_PIXEL) && s1_emit_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      res_valid_q <= s4_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rl_q <= s1_rl_q;
      s2_fl_q <= s1_fl_q;
      s3_rl_q <= s2_rl_q;
      s3_fl_q <= s2_fl_q;
      s4_rl_q <= s3_rl_q;
      s4_fl_q <= s3_fl_q;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        rs_q[i] <= rs_d[i];
      end
      if (s4_valid_q) begin
        res_conv_q <= sum_d;
        res_rl_q   <= s4_rl_q;
        res_fl_q   <= s4_fl_q;
      end
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.conv_value = res_conv_q;
  assign result_o.row_last   = res_rl_q;
  assign result_o.frame_last = res_fl_q;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < (COL_W+1)'(wc)))
    else $error("column counter beyond frame width");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ROW_W+1)'(row_q) < (ROW_W+1)'(hc)))
    else $error("row counter beyond frame height");
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_fl_q) |-> res_rl_q)
    else $error("frame end without row end");
  a_weight_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && (op_e'(s1_op_q) == OP_WEIGHT)) |=> !s2_valid_q)
    else $error("weight beat produced a result");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s4_valid_q) |=> res_valid_q)
    else $error("result lost at output register");
`endif
endmodule

[tb/sv/scs_conv_checker.sv]
// Scoreboard of the strided convolution stream: watches the item, config and result channels,
// predicts every window sum and compares each result beat against it.
// Depends on scs_pkg and the channel interfaces in scs_chan_if.sv.
module scs_conv_checker import scs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  scs_item_if    item,
  scs_result_if  result,
  scs_cfg_if     cfg,
  output int     fail_count_o,
  output int     pending_o
);

  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic                     row_last;
    logic                     frame_last;
  } conv_beat_t;

  conv_beat_t conv_queue[$];

  // Shadow of line buffers, window, kernel and counters
  logic signed [PIX_W-1:0] line_mem [MAX_KERNEL*MAX_WIDTH];
  logic signed [PIX_W-1:0] win      [MAX_KERNEL][MAX_KERNEL];
  logic signed [PIX_W-1:0] kernel_w [NWEIGHT];
  int                      col_cnt;
  int                      row_cnt;

  logic [FW_W-1:0] frame_w;
  logic [FH_W-1:0] frame_h;
  logic [KS_W-1:0] k_rows;
  logic [KS_W-1:0] k_cols;
  logic [KS_W-1:0] stride;

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Shift one pixel into the window and queue the window sum when on the stride grid
  task automatic predict_pixel(input logic signed [PIX_W-1:0] pix);
    int w, h, kr, kc, s, r, c, slot, x, y;
    longint acc;
    conv_beat_t beat;
    w  = clamp_dim(frame_w, MAX_WIDTH);
    h  = clamp_dim(frame_h, MAX_HEIGHT);
    kr = clamp_dim(k_rows, MAX_KERNEL);
    kc = clamp_dim(k_cols, MAX_KERNEL);
    s  = clamp_dim(stride, MAX_STEP);
    r  = (row_cnt >= h) ? 0 : row_cnt;
    c  = (col_cnt >= w) ? 0 : col_cnt;
    for (int i = 0; i < MAX_KERNEL; i++)
      for (int j = 0; j < MAX_KERNEL - 1; j++)
        win[i][j] = win[i][j+1];
    win[0][MAX_KERNEL-1] = pix;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      slot = (r % MAX_KERNEL + MAX_KERNEL - d) % MAX_KERNEL;
      win[d][MAX_KERNEL-1] = line_mem[slot*MAX_WIDTH + c];
    end
    line_mem[(r % MAX_KERNEL)*MAX_WIDTH + c] = pix;
    if (w >= kc && h >= kr && r + 1 >= kr && c + 1 >= kc) begin
      y = r + 1 - kr;
      x = c + 1 - kc;
      if (y % s == 0 && x % s == 0) begin
        acc = 0;
        for (int k1 = 0; k1 < kr; k1++)
          for (int k2 = 0; k2 < kc; k2++)
            acc += longint'(win[kr-1-k1][MAX_KERNEL-kc+k2]) * longint'(kernel_w[k1*kc+k2]);
        beat.conv_value = acc[CONV_W-1:0];
        beat.row_last   = (x == ((w - kc) / s) * s);
        beat.frame_last = beat.row_last && (y == ((h - kr) / s) * s);
        conv_queue.insert(conv_queue.size(), beat);
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  // Track config, items and results at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    conv_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NWEIGHT; i++) kernel_w[i] = '0;
      for (int i = 0; i < MAX_KERNEL; i++)
        for (int j = 0; j < MAX_KERNEL; j++) win[i][j] = '0;
      for (int i = 0; i < MAX_KERNEL*MAX_WIDTH; i++) line_mem[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      frame_w = FW_W'(64);
      frame_h = FH_W'(64);
      k_rows  = KS_W'(3);
      k_cols  = KS_W'(3);
      stride  = KS_W'(1);
      conv_queue.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FRAME_WIDTH:  frame_w = cfg.data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_h = cfg.data[FH_W-1:0];
          REG_KERNEL_ROWS:  k_rows  = cfg.data[KS_W-1:0];
          REG_KERNEL_COLS:  k_cols  = cfg.data[KS_W-1:0];
          REG_STEP_SIZE:    stride  = cfg.data[KS_W-1:0];
          default: ;
        endcase
        if (cfg.index <= REG_STEP_SIZE) begin
          col_cnt = 0;
          row_cnt = 0;
        end
      end
      if (item.valid && item.ready) begin
        if (item.opcode == OP_WEIGHT) kernel_w[item.weight_index] = item.weight_value;
        else predict_pixel(item.pixel_value);
      end
      if (result.valid && result.ready) begin
        if (conv_queue.size() == 0) begin
          report_mismatch("unexpected result conv_value", result.conv_value, 0);
        end else begin
          want = conv_queue.pop_front();
          if (result.conv_value !== want.conv_value)
            report_mismatch("conv_value", result.conv_value, want.conv_value);
          if (result.row_last !== want.row_last)
            report_mismatch("row_last", result.row_last, want.row_last);
          if (result.frame_last !== want.frame_last)
            report_mismatch("frame_last", result.frame_last, want.frame_last);
        end
      end
      pending_o = conv_queue.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the strided convolution stream testbench: clock, reset, config phases, item stimulus
// and result back-pressure. Depends on scs_pkg, scs_chan_if.sv and scs_conv_checker.sv.
module tb_top;
  import scs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 20;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  scs_item_if   item_ch ();
  scs_result_if result_ch ();
  scs_cfg_if    cfg_ch ();

  strided_conv2d_stream_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  scs_conv_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item         (item_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run if it hangs
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic send_item(input op_e op, input logic [WIDX_W-1:0] idx,
                           input logic [PIX_W-1:0] wval, input logic [PIX_W-1:0] pval);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= op;
    item_ch.weight_index <= idx;
    item_ch.weight_value <= wval;
    item_ch.pixel_value  <= pval;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  // Hold until every expected result is back and the pipeline has emptied
  task automatic wait_drained();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input int fw, input int fh, input int kr, input int kc, input int st);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
    write_reg(REG_KERNEL_ROWS, CFG_DATA_W'(kr));
    write_reg(REG_KERNEL_COLS, CFG_DATA_W'(kc));
    write_reg(REG_STEP_SIZE, CFG_DATA_W'(st));
  endtask

  // Random phase: mostly pixels, with weight reloads mixed in
  task automatic run_phase(input int fw, input int fh, input int kr, input int kc,
                           input int st, input int n_items, input int mode);
    int used;
    logic [WIDX_W-1:0] idx;
    wait_drained();
    configure(fw, fh, kr, kc, st);
    set_idling(mode);
    used = ((kr == 0) ? 1 : (kr > MAX_KERNEL ? MAX_KERNEL : kr))
         * ((kc == 0) ? 1 : (kc > MAX_KERNEL ? MAX_KERNEL : kc));
    // Load the used kernel first
    for (int i = 0; i < used; i++)
      send_item(OP_WEIGHT, WIDX_W'(i), PIX_W'($urandom), PIX_W'($urandom));
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < 12) begin
        idx = ($urandom_range(1) == 1) ? WIDX_W'($urandom_range(used - 1))
                                       : WIDX_W'($urandom_range(NWEIGHT - 1));
        send_item(OP_WEIGHT, idx, PIX_W'($urandom), PIX_W'($urandom));
      end else begin
        send_item(OP_PIXEL, WIDX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [PIX_W-1:0] edge_pix [4];
    edge_pix[0] = 16'h8000;
    edge_pix[1] = 16'h7FFF;
    edge_pix[2] = 16'h0000;
    edge_pix[3] = 16'hFFFF;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    item_ch.valid        = 1'b0;
    item_ch.opcode       = OP_WEIGHT;
    item_ch.weight_index = '0;
    item_ch.weight_value = '0;
    item_ch.pixel_value  = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_FRAME_WIDTH;
    cfg_ch.data          = '0;
    rst_ni               = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: 4x3 frame, 3x3 kernel at extreme weights, extreme pixels
    configure(4, 3, 3, 3, 1);
    write_reg(REG_UNMAPPED, 13'h1FFF);
    send_item(OP_WEIGHT, 6'd0, 16'h8000, 16'h0000);
    send_item(OP_WEIGHT, 6'd8, 16'h7FFF, 16'hFFFF);
    send_item(OP_WEIGHT, 6'd4, 16'h8000, 16'h0000);
    send_item(OP_WEIGHT, 6'd63, 16'h7FFF, 16'h0000);
    for (int i = 0; i < 12; i++)
      send_item(OP_PIXEL, 6'd0, 16'h0000, edge_pix[i % 4]);
    send_item(OP_WEIGHT, 6'd8, 16'hFFFF, 16'h0000);
    for (int i = 0; i < 4; i++)
      send_item(OP_PIXEL, 6'd63, 16'hFFFF, 16'h8000);

    // Random phases across sizes, strides and out-of-range register values
    run_phase(8, 8, 3, 3, 1, 200, 0);
    run_phase(5, 6, 2, 3, 2, 200, 1);
    run_phase(1, 0, 1, 1, 0, 100, 2);
    run_phase(16, 4, 8, 8, 8, 100, 3);
    run_phase(13'h1FFF, 1, 1, 8, 15, 100, 1);
    run_phase(12, 8191, 8, 8, 3, 200, 2);
    run_phase(9, 5, 0, 15, 2, 150, 3);
    run_phase(6, 6, 4, 5, 3, 200, 0);
    run_phase(7, 9, 2, 2, 1, 200, 3);

    wait_drained();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
sv/scs_pkg.sv
sv/scs_chan_if.sv
sv/scs_ram.sv
sv/scs_col_cell.sv
sv/strided_conv2d_stream_top.sv
tb/sv/scs_conv_checker.sv
tb/sv/tb_top.sv
